### design/assert_macros.svh
// assertion helpers shared by mbrtu_core and mbrtu_tx
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

### design/mbrtu_pkg.sv
package mbrtu_pkg;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_BYTE  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_TIMEOUT  = 3'd1;
    localparam logic [2:0] ST_HEADER   = 3'd2;
    localparam logic [2:0] ST_CRC      = 3'd3;
    localparam logic [2:0] ST_DISABLED = 3'd4;

    localparam logic CFG_ENABLED = 1'b0;
    localparam logic CFG_TIMEOUT = 1'b1;

    localparam logic [15:0] DEFAULT_TIMEOUT = 16'd2500;
    localparam logic [15:0] CRC_INIT        = 16'hFFFF;
    localparam logic [15:0] CRC_POLY        = 16'hA001;
    localparam logic [15:0] ELAPSED_MAX     = 16'hFFFF;
    localparam logic [7:0]  FUNC_READ       = 8'h03;
    localparam logic [7:0]  RESP_BYTES      = 8'h02;
    localparam logic [7:0]  COUNT_HIGH      = 8'h00;
    localparam logic [7:0]  COUNT_LOW       = 8'h01;

    typedef struct packed {
        logic        frame;
        logic        done;
        logic [7:0]  slave;
        logic [15:0] addr;
        logic [2:0]  status;
        logic [15:0] value;
    } req_t;

    typedef struct packed {
        logic frame_active;
        logic done_full;
    } tx_state_t;

    function automatic logic [15:0] crc_add(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

### design/mbrtu_core.sv
`include "assert_macros.svh"

module mbrtu_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,
    input  logic [1:0]           s_tuser,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [15:0]          cfg_wdata,
    input  mbrtu_pkg::tx_state_t tx_state,
    output mbrtu_pkg::req_t      req
);

    logic        in_valid_reg;
    logic [1:0]  in_op_reg;
    logic [7:0]  in_sid_reg;
    logic [15:0] in_addr_reg;
    logic [7:0]  in_rx_reg;

    logic        enabled_reg;
    logic [15:0] timeout_reg;

    logic        busy_reg, busy_next;
    logic [2:0]  byte_count_reg, byte_count_next;
    logic [15:0] crc_reg, crc_next;
    logic [15:0] elapsed_reg, elapsed_next;
    logic [7:0]  target_reg, target_next;
    logic        header_good_reg, header_good_next;
    logic [15:0] data_word_reg, data_word_next;
    logic [7:0]  crc_low_reg, crc_low_next;

    logic        gen_frame;
    logic        gen_done;
    logic [2:0]  done_status;
    logic [15:0] done_value;
    logic [15:0] elapsed_inc;
    logic        can_go;
    logic        consume;

    assign elapsed_inc = (elapsed_reg == mbrtu_pkg::ELAPSED_MAX) ? elapsed_reg
                                                                 : elapsed_reg + 16'd1;

    always_comb
    begin
        busy_next        = busy_reg;
        byte_count_next  = byte_count_reg;
        crc_next         = crc_reg;
        elapsed_next     = elapsed_reg;
        target_next      = target_reg;
        header_good_next = header_good_reg;
        data_word_next   = data_word_reg;
        crc_low_next     = crc_low_reg;
        gen_frame        = 1'b0;
        gen_done         = 1'b0;
        done_status      = mbrtu_pkg::ST_OK;
        done_value       = 16'd0;
        if (in_valid_reg)
        begin
            unique case (in_op_reg)
                mbrtu_pkg::OP_START:
                begin
                    if (!busy_reg)
                    begin
                        if (!enabled_reg)
                        begin
                            gen_done    = 1'b1;
                            done_status = mbrtu_pkg::ST_DISABLED;
                        end
                        else
                        begin
                            gen_frame        = 1'b1;
                            busy_next        = 1'b1;
                            byte_count_next  = 3'd0;
                            crc_next         = mbrtu_pkg::CRC_INIT;
                            elapsed_next     = 16'd0;
                            target_next      = in_sid_reg;
                            header_good_next = 1'b1;
                            data_word_next   = 16'd0;
                            crc_low_next     = 8'd0;
                        end
                    end
                end
                mbrtu_pkg::OP_BYTE:
                begin
                    if (busy_reg)
                    begin
                        if (elapsed_reg >= timeout_reg)
                        begin
                            gen_done    = 1'b1;
                            done_status = mbrtu_pkg::ST_TIMEOUT;
                        end
                        else
                        begin
                            unique case (byte_count_reg)
                                3'd0:
                                begin
                                    if (in_rx_reg != target_reg)
                                        header_good_next = 1'b0;
                                end
                                3'd1:
                                begin
                                    if (in_rx_reg != mbrtu_pkg::FUNC_READ)
                                        header_good_next = 1'b0;
                                end
                                3'd2:
                                begin
                                    if (in_rx_reg != mbrtu_pkg::RESP_BYTES)
                                        header_good_next = 1'b0;
                                end
                                3'd3:
                                begin
                                    data_word_next = {in_rx_reg, 8'h00};
                                end
                                3'd4:
                                begin
                                    data_word_next = {data_word_reg[15:8], in_rx_reg};
                                end
                                3'd5:
                                begin
                                    crc_low_next = in_rx_reg;
                                end
                                default:
                                begin
                                    gen_done = 1'b1;
                                    if (!header_good_reg)
                                        done_status = mbrtu_pkg::ST_HEADER;
                                    else if ({in_rx_reg, crc_low_reg} != crc_reg)
                                        done_status = mbrtu_pkg::ST_CRC;
                                    else
                                    begin
                                        done_status = mbrtu_pkg::ST_OK;
                                        done_value  = data_word_reg;
                                    end
                                end
                            endcase
                            if (byte_count_reg < 3'd5)
                                crc_next = mbrtu_pkg::crc_add(crc_reg, in_rx_reg);
                            if (byte_count_reg < 3'd6)
                                byte_count_next = byte_count_reg + 3'd1;
                        end
                    end
                end
                mbrtu_pkg::OP_TICK:
                begin
                    if (busy_reg)
                    begin
                        elapsed_next = elapsed_inc;
                        if (elapsed_inc >= timeout_reg)
                        begin
                            gen_done    = 1'b1;
                            done_status = mbrtu_pkg::ST_TIMEOUT;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (gen_done)
            busy_next = 1'b0;
    end

    // a result needs room behind whatever the buffer still holds
    assign can_go  = !(gen_frame && (tx_state.frame_active || tx_state.done_full))
                  && !(gen_done && tx_state.done_full);
    assign consume = in_valid_reg && can_go;
    assign s_tready = !in_valid_reg || consume;

    assign req.frame  = consume && gen_frame;
    assign req.done   = consume && gen_done;
    assign req.slave  = in_sid_reg;
    assign req.addr   = in_addr_reg;
    assign req.status = done_status;
    assign req.value  = done_value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_op_reg   <= s_tuser;
            in_sid_reg  <= s_tdata[7:0];
            in_addr_reg <= s_tdata[23:8];
            in_rx_reg   <= s_tdata[31:24];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg <= 1'b0;
            timeout_reg <= mbrtu_pkg::DEFAULT_TIMEOUT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mbrtu_pkg::CFG_ENABLED: enabled_reg <= cfg_wdata[0];
                mbrtu_pkg::CFG_TIMEOUT: timeout_reg <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg        <= 1'b0;
            byte_count_reg  <= 3'd0;
            crc_reg         <= mbrtu_pkg::CRC_INIT;
            elapsed_reg     <= 16'd0;
            target_reg      <= 8'd0;
            header_good_reg <= 1'b0;
            data_word_reg   <= 16'd0;
            crc_low_reg     <= 8'd0;
        end
        else if (consume)
        begin
            busy_reg        <= busy_next;
            byte_count_reg  <= byte_count_next;
            crc_reg         <= crc_next;
            elapsed_reg     <= elapsed_next;
            target_reg      <= target_next;
            header_good_reg <= header_good_next;
            data_word_reg   <= data_word_next;
            crc_low_reg     <= crc_low_next;
        end
    end

    `ASSERT_PROP(a_frame_makes_busy, clk, rst_n, req.frame |=> busy_reg)
    `ASSERT_PROP(a_done_ends_busy, clk, rst_n, req.done |=> !busy_reg)
    `ASSERT_NEVER(a_frame_and_done, clk, rst_n, gen_frame && gen_done)

endmodule

### design/mbrtu_tx.sv
`include "assert_macros.svh"

module mbrtu_tx (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mbrtu_pkg::req_t      req,
    output mbrtu_pkg::tx_state_t tx_state,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,
    output logic                 m_tlast,
    output logic                 m_tuser
);

    logic        active_reg;
    logic [2:0]  idx_reg;
    logic [7:0]  slave_reg;
    logic [15:0] addr_reg;
    logic [15:0] crc_reg;

    logic        done_full_reg;
    logic [2:0]  done_status_reg;
    logic [15:0] done_value_reg;

    logic [7:0]  cur_byte;
    logic        take;
    logic        take_byte;
    logic        take_done;

    always_comb
    begin
        unique case (idx_reg)
            3'd0:    cur_byte = slave_reg;
            3'd1:    cur_byte = mbrtu_pkg::FUNC_READ;
            3'd2:    cur_byte = addr_reg[15:8];
            3'd3:    cur_byte = addr_reg[7:0];
            3'd4:    cur_byte = mbrtu_pkg::COUNT_HIGH;
            3'd5:    cur_byte = mbrtu_pkg::COUNT_LOW;
            3'd6:    cur_byte = crc_reg[7:0];
            default: cur_byte = crc_reg[15:8];
        endcase
    end

    assign m_tvalid  = active_reg || done_full_reg;
    assign take      = m_tvalid && m_tready;
    assign take_byte = take && active_reg;
    assign take_done = take && !active_reg;

    // request bytes go first, a queued completion follows them
    always_comb
    begin
        if (active_reg)
        begin
            m_tuser = 1'b0;
            m_tlast = (idx_reg == 3'd7);
            m_tdata = {5'd0, 16'd0, mbrtu_pkg::ST_OK, cur_byte};
        end
        else
        begin
            m_tuser = 1'b1;
            m_tlast = 1'b1;
            m_tdata = {5'd0, done_value_reg, done_status_reg, 8'd0};
        end
    end

    assign tx_state.frame_active = active_reg;
    assign tx_state.done_full    = done_full_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            idx_reg    <= 3'd0;
            crc_reg    <= mbrtu_pkg::CRC_INIT;
        end
        else if (req.frame)
        begin
            active_reg <= 1'b1;
            idx_reg    <= 3'd0;
            crc_reg    <= mbrtu_pkg::CRC_INIT;
        end
        else if (take_byte)
        begin
            if (idx_reg < 3'd6)
                crc_reg <= mbrtu_pkg::crc_add(crc_reg, cur_byte);
            if (idx_reg == 3'd7)
                active_reg <= 1'b0;
            idx_reg <= idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.frame)
        begin
            slave_reg <= req.slave;
            addr_reg  <= req.addr;
        end
        if (req.done)
        begin
            done_status_reg <= req.status;
            done_value_reg  <= req.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_full_reg <= 1'b0;
        end
        else if (req.done)
        begin
            done_full_reg <= 1'b1;
        end
        else if (take_done)
        begin
            done_full_reg <= 1'b0;
        end
    end

    `ASSERT_NEVER(a_frame_into_busy, clk, rst_n, req.frame && (active_reg || done_full_reg))
    `ASSERT_NEVER(a_done_overrun, clk, rst_n, req.done && done_full_reg)
    `ASSERT_PROP(a_last_byte_ends, clk, rst_n, (take_byte && idx_reg == 3'd7) |=> !active_reg)

endmodule

### design/modbus_rtu_read_register_master.sv
// Modbus RTU master for a function-3 read of one holding register. Items on the s_ side are a
// start (sends the 8-byte request, last byte on tlast), a received response byte, or a
// millisecond tick; each transaction ends in one completion result (tuser 1) carrying status
// and the register value. Bytes and ticks are taken one per cycle unless a result must wait
// for room. A start puts the request into a frame sequencer that hands out one byte per cycle
// while m_tready is high, updating the request CRC as it goes; bytes and ticks keep flowing
// in meanwhile, and an item that would cause a result waits in the input register until the
// result buffer (frame sequencer plus one completion slot) has room. A result is registered
// into that buffer when its item leaves the input register.

module modbus_rtu_read_register_master (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // slave_id, register_address, rx_byte
    input  logic [1:0]  s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // tx_byte, status, read_value, zero pad
    output logic        m_tlast,
    output logic        m_tuser,   // result_kind
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata
);

    mbrtu_pkg::req_t      req;
    mbrtu_pkg::tx_state_t tx_state;

    mbrtu_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .tx_state  (tx_state),
        .req       (req)
    );

    mbrtu_tx u_tx (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .tx_state (tx_state),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
